>>> src/b45_pkg.sv
// b45_pkg: shared types, constants and the alphabet lookup for the base45 decoder
// no dependencies; imported by every module of the decoder
package b45_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0]  DIGIT_BAD    = 6'd63;
    localparam logic [15:0] CAPACITY_RST = 16'hFFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       ends;
    } text_item_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       error;
        logic       done_res;
    } result_item_t;

    // work passed from front to back
    typedef enum logic [1:0] {
        OP_ONE = 2'd0,   // final pair, one octet
        OP_TWO = 2'd1,   // full group, two octets high first
        OP_ERR = 2'd2    // refused text
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] data;
        logic        last;
    } queue_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // alphabet position of a byte code, DIGIT_BAD when not in the alphabet
    function automatic logic [5:0] digit_of(logic [7:0] c);
        logic [5:0] d;
        d = DIGIT_BAD;
        priority if (c >= 8'h30 && c <= 8'h39) d = 6'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h5A)     d = 6'(c - 8'h41 + 8'd10);
        else if (c == 8'h20)                   d = 6'd36;
        else if (c == 8'h24)                   d = 6'd37;
        else if (c == 8'h25)                   d = 6'd38;
        else if (c == 8'h2A)                   d = 6'd39;
        else if (c == 8'h2B)                   d = 6'd40;
        else if (c == 8'h2D)                   d = 6'd41;
        else if (c == 8'h2E)                   d = 6'd42;
        else if (c == 8'h2F)                   d = 6'd43;
        else if (c == 8'h3A)                   d = 6'd44;
        else                                   d = DIGIT_BAD;
        return d;
    endfunction

endpackage

>>> src/b45_front.sv
// b45_front: accepts characters, tracks group state, checks limits, queues work
// depends on b45_pkg
module b45_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  b45_pkg::text_item_t item,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output logic                push,
    output b45_pkg::queue_entry_t push_entry
);
    import b45_pkg::*;

    logic [15:0] capacity_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [5:0]  first_reg, first_next;
    logic [5:0]  second_reg, second_next;
    logic [15:0] emitted_reg, emitted_next;
    logic        discard_reg, discard_next;

    logic [5:0]  d;
    logic [11:0] pair_val;
    logic [16:0] group_val;
    logic [16:0] need_one, need_two;
    logic        clear_text;

    assign d         = digit_of(item.char_code);
    assign pair_val  = {6'd0, first_reg} + 12'(d) * 12'd45;
    assign group_val = {11'd0, first_reg} + 17'(second_reg) * 17'd45 + 17'(d) * 17'd2025;
    assign need_one  = {1'b0, emitted_reg} + 17'd1;
    assign need_two  = {1'b0, emitted_reg} + 17'd2;

    always_comb
    begin
        pos_next     = pos_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        emitted_next = emitted_reg;
        discard_next = discard_reg;
        clear_text   = 1'b0;
        push         = 1'b0;
        push_entry   = '{op: OP_ERR, data: 16'd0, last: 1'b1};
        if (accept)
        begin
            priority if (discard_reg)
            begin
                clear_text = item.ends;
            end
            else if (d == DIGIT_BAD)
            begin
                push         = 1'b1;
                clear_text   = item.ends;
                discard_next = ~item.ends;
            end
            else if (pos_reg == 2'd0)
            begin
                if (item.ends)
                begin
                    push       = 1'b1;
                    clear_text = 1'b1;
                end
                else
                begin
                    first_next = d;
                    pos_next   = 2'd1;
                end
            end
            else if (pos_reg == 2'd1)
            begin
                if (!item.ends)
                begin
                    second_next = d;
                    pos_next    = 2'd2;
                end
                else
                begin
                    push       = 1'b1;
                    clear_text = 1'b1;
                    if (pair_val <= 12'd255 && need_one <= {1'b0, capacity_reg})
                        push_entry = '{op: OP_ONE, data: {4'd0, pair_val}, last: 1'b1};
                end
            end
            else
            begin
                push = 1'b1;
                if (group_val > 17'h0FFFF || need_two > {1'b0, capacity_reg})
                begin
                    clear_text   = item.ends;
                    discard_next = ~item.ends;
                end
                else
                begin
                    push_entry = '{op: OP_TWO, data: group_val[15:0], last: item.ends};
                    clear_text = item.ends;
                    if (!item.ends)
                    begin
                        emitted_next = need_two[15:0];
                        pos_next     = 2'd0;
                        first_next   = 6'd0;
                        second_next  = 6'd0;
                    end
                end
            end
            if (clear_text)
            begin
                pos_next     = 2'd0;
                first_next   = 6'd0;
                second_next  = 6'd0;
                emitted_next = 16'd0;
                discard_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
            pos_reg      <= 2'd0;
            first_reg    <= 6'd0;
            second_reg   <= 6'd0;
            emitted_reg  <= 16'd0;
            discard_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            emitted_reg <= emitted_next;
            discard_reg <= discard_next;
        end
    end

endmodule

>>> src/b45_queue.sv
// b45_queue: short fifo of decode work between front and back
// depends on b45_pkg
module b45_queue #(
    parameter int DEPTH = b45_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b45_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output b45_pkg::queue_entry_t head_entry,
    output b45_pkg::queue_status_t status
);
    import b45_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.empty = (count_reg == CNT_W'(0));
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign head_entry   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // occupancy bookkeeping
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count missed a push");

endmodule

>>> src/b45_back.sv
// b45_back: turns queued work into octet transactions through an output register
// depends on b45_pkg
module b45_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b45_pkg::queue_entry_t  head_entry,
    input  b45_pkg::queue_status_t status,
    output logic                   pop,
    input  logic                   result_stall,
    output logic                   result_valid,
    output b45_pkg::result_item_t  result_item
);
    import b45_pkg::*;

    logic         valid_reg, valid_next;
    logic         half_reg, half_next;
    result_item_t item_reg, item_next;
    logic         load;

    assign load         = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        item_next  = item_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !status.empty;
            if (!status.empty)
            begin
                unique case (head_entry.op)
                    OP_ONE:
                    begin
                        item_next = '{octet: head_entry.data[7:0], error: 1'b0, done_res: 1'b1};
                        pop       = 1'b1;
                    end
                    OP_TWO:
                    begin
                        if (!half_reg)
                        begin
                            item_next = '{octet: head_entry.data[15:8], error: 1'b0,
                                          done_res: 1'b0};
                            half_next = 1'b1;
                        end
                        else
                        begin
                            item_next = '{octet: head_entry.data[7:0], error: 1'b0,
                                          done_res: head_entry.last};
                            half_next = 1'b0;
                            pop       = 1'b1;
                        end
                    end
                    default:
                    begin
                        item_next = '{octet: 8'd0, error: 1'b1, done_res: 1'b1};
                        pop       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

>>> src/base45_stream_decoder_top.sv
// base45_stream_decoder_top: base45 text decoder, front / queue / back
// depends on b45_pkg, b45_front, b45_queue, b45_back
//
//  channel   direction  handshake                 payload
//  text      in         text_valid / text_stall   text_item_t   (char_code, ends)
//  result    out        result_valid / result_stall result_item_t (octet, error, done_res)
//  cfg       in         cfg_wr_en                 cfg_wr_data   (capacity_octets)
//
// one character transaction per cycle while text_stall is low; a group of three gives two octets
// from character to octet: queue write then output register
// text_stall rises only while the work queue is full, set by back-side stalls
// rst_n clears text state, queue and output; capacity returns to 65535
// a stalled result holds in the output register while the front keeps filling the queue
module base45_stream_decoder_top #(
    parameter int QUEUE_DEPTH = b45_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_stall,
    input  b45_pkg::text_item_t   text_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output b45_pkg::result_item_t result_item,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data
);
    import b45_pkg::*;

    logic          accept;
    logic          push, pop;
    queue_entry_t  push_entry, head_entry;
    queue_status_t status;

    // front takes a character whenever the queue has room
    assign text_stall = status.full;
    assign accept     = text_valid && !text_stall;

    b45_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (text_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decouples character intake from octet delivery
    b45_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (status)
    );

    b45_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (head_entry),
        .status       (status),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item)
    );

endmodule

>>> sim/tb_base45_stream_decoder_top.sv
// testbench for base45_stream_decoder_top: directed table then random base45 texts
// depends on b45_pkg and the decoder RTL; results checked against an in-bench decoder
`timescale 1ns / 100ps

module tb_base45_stream_decoder_top;

    import b45_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;        // queue write and output register plus margin
    localparam int RANDOM_ITEMS  = 1950;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int REPORT_LIMIT  = 50;

    localparam string B45_ALPHABET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

    // result constants used by the table
    localparam result_item_t NO_RESULT = '0;
    localparam result_item_t REFUSED   = '{octet: 8'h00, error: 1'b1, done_res: 1'b1};
    localparam result_item_t ZERO_MID  = '{octet: 8'h00, error: 1'b0, done_res: 1'b0};
    localparam result_item_t ZERO_LAST = '{octet: 8'h00, error: 1'b0, done_res: 1'b1};
    localparam result_item_t FF_MID    = '{octet: 8'hFF, error: 1'b0, done_res: 1'b0};
    localparam result_item_t FF_LAST   = '{octet: 8'hFF, error: 1'b0, done_res: 1'b1};

    // one row of the directed table; typed rows carry their own results
    typedef struct packed {
        logic [7:0]   code;
        logic         ends;
        logic         cfg;      // write capacity before this character
        logic [15:0]  cap;
        logic         typed;
        logic [1:0]   n;
        result_item_t r0;
        result_item_t r1;
    } plan_row_t;

    localparam int PLAN_ROWS = 24;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // smallest group, right after reset
        '{"0",   1'b0, 1'b0, 16'h0000, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b0, 1'b0, 16'h0000, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd2, ZERO_MID,  ZERO_LAST},
        // largest group, then largest final pair
        '{"F",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"G",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"W",   1'b0, 1'b0, 16'h0000, 1'b1, 2'd2, FF_MID,    FF_MID},
        '{"U",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"5",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd1, FF_LAST,   NO_RESULT},
        // group one over 65535, on the final character
        '{"G",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"G",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"W",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd1, REFUSED,   NO_RESULT},
        // final pair one over 255
        '{"V",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"5",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd1, REFUSED,   NO_RESULT},
        // lone final character
        '{":",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd1, REFUSED,   NO_RESULT},
        // byte zero mid-text, then silence until the final character
        '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 2'd1, REFUSED,   NO_RESULT},
        '{"A",   1'b0, 1'b0, 16'h0000, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, 16'h0000, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
        // zero capacity refuses even one octet
        '{"A",   1'b0, 1'b1, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd1, REFUSED,   NO_RESULT},
        // capacity two: one group fits, then capacity lowered mid-text
        '{"0",   1'b0, 1'b1, 16'h0002, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"1",   1'b0, 1'b0, 16'h0000, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b0, 1'b1, 16'h0001, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"0",   1'b1, 1'b0, 16'h0000, 1'b1, 2'd1, REFUSED,   NO_RESULT}
    };

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         text_valid   = 1'b0;
    logic         text_stall;
    text_item_t   text_item    = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;
    logic         cfg_wr_en    = 1'b0;
    logic [15:0]  cfg_wr_data  = '0;

    // table row that travels with the text transaction on the bus
    plan_row_t    cur_row      = '0;

    // decoder model state
    logic [1:0]   held;
    logic [5:0]   dig0;
    logic [5:0]   dig1;
    logic [15:0]  out_cnt;
    logic         dropping;
    logic [15:0]  cap_limit;

    result_item_t octets_due [$];
    int           mismatches   = 0;
    int           random_sent  = 0;
    int unsigned  cycles       = 0;

    result_item_t pred0;
    result_item_t pred1;
    result_item_t want;
    int           n_pred;

    base45_stream_decoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    function automatic logic [5:0] alpha_pos(input logic [7:0] code);
        logic [5:0] pos;
        pos = DIGIT_BAD;
        for (int k = 0; k < 45; k++)
        begin
            if (8'(B45_ALPHABET[k]) == code)
                pos = 6'(k);
        end
        return pos;
    endfunction

    function automatic void clear_text();
        held     = 2'd0;
        dig0     = '0;
        dig1     = '0;
        out_cnt  = '0;
        dropping = 1'b0;
    endfunction

    // refusal: one error result, then drop until the final character
    function automatic int refuse(input logic ends, output result_item_t r);
        r = REFUSED;
        if (ends)
            clear_text();
        else
            dropping = 1'b1;
        return 1;
    endfunction

    function automatic int decode_char(input logic [7:0] code, input logic ends,
                                       output result_item_t r0, output result_item_t r1);
        logic [5:0]  d;
        int unsigned v;
        r0 = NO_RESULT;
        r1 = NO_RESULT;
        if (dropping)
        begin
            if (ends)
                clear_text();
            return 0;
        end
        d = alpha_pos(code);
        if (d == DIGIT_BAD || (held == 2'd0 && ends))
            return refuse(ends, r0);
        if (held == 2'd0)
        begin
            dig0 = d;
            held = 2'd1;
            return 0;
        end
        if (held == 2'd1 && !ends)
        begin
            dig1 = d;
            held = 2'd2;
            return 0;
        end
        // final pair gives one octet
        if (held == 2'd1)
        begin
            v = dig0 + 45 * d;
            if (v > 255 || 32'(out_cnt) + 32'd1 > 32'(cap_limit))
                return refuse(ends, r0);
            r0 = '{octet: 8'(v), error: 1'b0, done_res: 1'b1};
            clear_text();
            return 1;
        end
        // full group gives two octets, high first
        v = dig0 + 45 * dig1 + 2025 * d;
        if (v > 65535 || 32'(out_cnt) + 32'd2 > 32'(cap_limit))
            return refuse(ends, r0);
        r0 = '{octet: 8'(v >> 8), error: 1'b0, done_res: 1'b0};
        r1 = '{octet: 8'(v), error: 1'b0, done_res: ends};
        if (ends)
            clear_text();
        else
        begin
            out_cnt = out_cnt + 16'd2;
            held    = 2'd0;
            dig0    = '0;
            dig1    = '0;
        end
        return 2;
    endfunction

    function automatic void compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        end
    endfunction

    // ---------------------------------------------------------------
    // monitor: predict on each accepted text transaction, check each
    // accepted result transaction against the oldest expectation
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cap_limit = CAPACITY_RST;
            clear_text();
        end
        else
        begin
            // capacity takes effect at the write edge
            if (cfg_wr_en)
                cap_limit = cfg_wr_data;
            if (text_valid && !text_stall)
            begin
                n_pred = decode_char(text_item.char_code, text_item.ends, pred0, pred1);
                // typed table rows override the model's results
                if (cur_row.typed)
                begin
                    n_pred = cur_row.n;
                    pred0  = cur_row.r0;
                    pred1  = cur_row.r1;
                end
                if (n_pred > 0)
                    octets_due.push_back(pred0);
                if (n_pred > 1)
                    octets_due.push_back(pred1);
            end
            if (result_valid && !result_stall)
            begin
                if (octets_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("result with nothing expected: octet 0x%0h error %0b done %0b",
                               result_item.octet, result_item.error, result_item.done_res);
                end
                else
                begin
                    want = octets_due.pop_front();
                    compare_field("octet", want.octet, result_item.octet);
                    compare_field("error", want.error, result_item.error);
                    compare_field("done_res", want.done_res, result_item.done_res);
                end
            end
        end
    end

    // watchdog, alone in its process
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("base45_stream_decoder_top verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // result side: random stalls, long stalls now and then, and quiet
    // stretches with no stall at all
    // ---------------------------------------------------------------

    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(40, 150)) @(posedge clk);
            end
            else if (mode == 2)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(10, 40))
                begin
                    result_stall <= ($urandom_range(0, 3) == 0);
                    @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // text side
    // ---------------------------------------------------------------

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid only drops when there is a gap, so it is never lowered and
    // raised within one step
    task automatic send_char(input logic [7:0] code, input logic ends, input int gap);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= '{char_code: code, ends: ends};
        do
            @(posedge clk);
        while (text_stall);
    endtask

    // hold off until every expected result is out, then let the pipe settle
    task automatic drain();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (octets_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_capacity();
        unique case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 6));
            2:       return 16'($urandom_range(0, 65535));
            3:       return 16'($urandom_range(7, 40));
            default: return CAPACITY_RST;
        endcase
    endfunction

    // alphabet character at a position up to hi, with rare raw bytes
    function automatic logic [7:0] alpha_char(input int hi);
        if ($urandom_range(0, 49) == 0)
            return 8'($urandom_range(0, 255));
        return 8'(B45_ALPHABET[$urandom_range(0, hi)]);
    endfunction

    // one random text: groups plus a final pair, a final group or a lone
    // character; some texts are raw noise with stray end marks
    task automatic send_random_text();
        text_item_t txt [$];
        int         groups;
        int         shape;
        int         gap_hi;
        groups = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
        shape  = $urandom_range(0, 9);
        if (shape == 9)
        begin
            repeat ($urandom_range(1, 6))
                txt.push_back('{char_code: 8'($urandom_range(0, 255)),
                                ends: ($urandom_range(0, 3) == 0)});
        end
        else
        begin
            if (shape >= 5 && shape <= 7 && groups == 0)
                groups = 1;
            repeat (groups)
            begin
                txt.push_back('{char_code: alpha_char(44), ends: 1'b0});
                txt.push_back('{char_code: alpha_char(44), ends: 1'b0});
                txt.push_back('{char_code: alpha_char(($urandom_range(0, 9) == 0) ? 44 : 32),
                                ends: 1'b0});
            end
            if (shape < 5)
            begin
                txt.push_back('{char_code: alpha_char(44), ends: 1'b0});
                txt.push_back('{char_code: alpha_char(($urandom_range(0, 4) == 0) ? 44 : 5),
                                ends: 1'b0});
            end
            else if (shape == 8)
                txt.push_back('{char_code: alpha_char(44), ends: 1'b0});
        end
        txt[txt.size() - 1].ends = 1'b1;
        // some texts go with no gaps at all
        gap_hi = ($urandom_range(0, 4) == 0) ? 0 : 1;
        foreach (txt[i])
        begin
            send_char(txt[i].char_code, txt[i].ends, gap_hi * idle_gap());
            random_sent++;
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (PLAN[i])
        begin
            if (PLAN[i].cfg)
                set_capacity(PLAN[i].cap);
            cur_row <= PLAN[i];
            send_char(PLAN[i].code, PLAN[i].ends, idle_gap());
        end
        set_capacity(CAPACITY_RST);
        cur_row <= '0;

        // random texts, capacity changed between them now and then
        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
                set_capacity(pick_capacity());
            else if ($urandom_range(0, 19) == 0)
                drain();
            send_random_text();
        end

        drain();
        if (mismatches == 0 && octets_due.size() == 0)
            $display("base45_stream_decoder_top verification clean");
        else
            $display("base45_stream_decoder_top verification failed");
        $finish;
    end

endmodule
